/* design/pcc_pkg.sv */
// Package: types and constants for the polygon containment classifier.
package pcc_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;
  localparam int SPECIES_BITS = 4;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int MAG_BITS     = COORD_BITS;
  localparam int PROD_BITS    = 2 * MAG_BITS;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_CLOSE = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [SPECIES_BITS-1:0] animal_species;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic                    inside_res;
    logic [SPECIES_BITS-1:0] pen_species;
    logic                    species_valid;
    logic [7:0]              contained_count;
    logic                    vertex_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch input item
    logic clear;
    logic add;
    logic rd;        // issue vertex read for edge_idx
    logic emit_test;
    logic emit_close;
    logic [IDX_BITS-1:0] edge_idx;
    logic first_rd;  // read of vertex 0 (also the wrap vertex)
  } cmd_t;

  // Datapath status to controller
  typedef struct packed {
    logic [CNT_BITS-1:0] vtotal;
    logic in_box;
  } stat_t;
endpackage

/* design/pcc_datapath.sv */
// Datapath: vertex memory, bounding box, edge crossing test and tallies.
module pcc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  pcc_pkg::in_item_t in_item,
  input  pcc_pkg::cmd_t     cmd,
  output pcc_pkg::stat_t    stat,
  output logic              out_strobe,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_z [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rdx_r, rdz_r;
  logic signed [COORD_BITS-1:0] v0x_r, v0z_r, sx_r, sz_r;
  logic signed [COORD_BITS-1:0] px_r, pz_r;
  logic [SPECIES_BITS-1:0] tag_r;
  logic [CNT_BITS-1:0] vtotal_r;
  logic signed [COORD_BITS-1:0] bminx_r, bmaxx_r, bminz_r, bmaxz_r;
  logic [7:0] tally_r;
  logic [SPECIES_BITS-1:0] first_r;
  logic agree_r, ovf_r, odd_r;
  logic rd_d_r, first_d_r, last_d_r;
  logic active_r, ln_r, rn_r;
  logic [PROD_BITS-1:0] lm_r, rm_r;
  logic out_strobe_r;
  out_item_t out_r;

  // Vertex memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.add && vtotal_r < CNT_BITS'(MAX_VERTICES)) begin
      mem_x[vtotal_r[IDX_BITS-1:0]] <= in_item.coord_x;
      mem_z[vtotal_r[IDX_BITS-1:0]] <= in_item.coord_z;
    end
    if (cmd.rd) begin
      rdx_r <= mem_x[cmd.edge_idx];
      rdz_r <= mem_z[cmd.edge_idx];
    end
  end

  // Edge endpoints: end = read vertex (or vertex 0 on wrap), start = previous
  logic signed [COORD_BITS-1:0] ex, ez;
  logic signed [DIFF_BITS-1:0] dx, dz, qx, qz;
  logic [MAG_BITS-1:0] mdx, mdz, mqx, mqz;
  logic straddle;
  always_comb begin
    ex = last_d_r ? v0x_r : rdx_r;
    ez = last_d_r ? v0z_r : rdz_r;
    dx = DIFF_BITS'(ex) - DIFF_BITS'(sx_r);
    dz = DIFF_BITS'(ez) - DIFF_BITS'(sz_r);
    qx = DIFF_BITS'(px_r) - DIFF_BITS'(sx_r);
    qz = DIFF_BITS'(pz_r) - DIFF_BITS'(sz_r);
    mdx = MAG_BITS'(dx[DIFF_BITS-1] ? -dx : dx);
    mdz = MAG_BITS'(dz[DIFF_BITS-1] ? -dz : dz);
    mqx = MAG_BITS'(qx[DIFF_BITS-1] ? -qx : qx);
    mqz = MAG_BITS'(qz[DIFF_BITS-1] ? -qz : qz);
    straddle = (pz_r > sz_r) != (pz_r > ez);
  end

  // Signed-magnitude compare of registered products
  logic lneg, rneg, less;
  always_comb begin
    lneg = ln_r && (lm_r != '0);
    rneg = rn_r && (rm_r != '0);
    if (lneg != rneg) less = lneg;
    else if (!lneg) less = lm_r < rm_r;
    else less = lm_r > rm_r;
  end

  logic hit;
  assign hit = cmd.emit_test && stat.in_box && odd_r;

  always_ff @(posedge clk) begin
    out_strobe_r <= 1'b0;
    if (!rst_n) begin
      vtotal_r <= '0;
      bminx_r <= '0; bmaxx_r <= '0; bminz_r <= '0; bmaxz_r <= '0;
      tally_r <= '0; first_r <= '0; agree_r <= 1'b1; ovf_r <= 1'b0;
      odd_r <= 1'b0; rd_d_r <= 1'b0; active_r <= 1'b0;
    end else begin
      rd_d_r    <= cmd.rd;
      first_d_r <= cmd.first_rd;
      last_d_r  <= cmd.rd && cmd.edge_idx == '0 && !cmd.first_rd;
      if (cmd.capture) begin
        px_r <= in_item.coord_x;
        pz_r <= in_item.coord_z;
        tag_r <= in_item.animal_species;
        odd_r <= 1'b0;
      end
      if (cmd.clear) begin
        vtotal_r <= '0;
        bminx_r <= '0; bmaxx_r <= '0; bminz_r <= '0; bmaxz_r <= '0;
        tally_r <= '0; first_r <= '0; agree_r <= 1'b1; ovf_r <= 1'b0;
      end
      if (cmd.add) begin
        if (vtotal_r >= CNT_BITS'(MAX_VERTICES)) begin
          ovf_r <= 1'b1;
        end else begin
          vtotal_r <= vtotal_r + 1'b1;
          if (vtotal_r == '0) begin
            bminx_r <= in_item.coord_x; bmaxx_r <= in_item.coord_x;
            bminz_r <= in_item.coord_z; bmaxz_r <= in_item.coord_z;
          end else begin
            if (in_item.coord_x < bminx_r) bminx_r <= in_item.coord_x;
            if (in_item.coord_x > bmaxx_r) bmaxx_r <= in_item.coord_x;
            if (in_item.coord_z < bminz_r) bminz_r <= in_item.coord_z;
            if (in_item.coord_z > bmaxz_r) bmaxz_r <= in_item.coord_z;
          end
        end
      end
      // Multiply stage: one edge per read result; the first read only latches vertex 0
      active_r <= 1'b0;
      if (rd_d_r) begin
        if (first_d_r) begin
          v0x_r <= rdx_r; v0z_r <= rdz_r;
        end else begin
          active_r <= straddle;
          ln_r <= qx[DIFF_BITS-1];
          rn_r <= (qz[DIFF_BITS-1] != dx[DIFF_BITS-1]) != dz[DIFF_BITS-1];
          lm_r <= PROD_BITS'(mqx) * PROD_BITS'(mdz);
          rm_r <= PROD_BITS'(mqz) * PROD_BITS'(mdx);
        end
        sx_r <= ex; sz_r <= ez;
      end
      if (active_r && less) odd_r <= !odd_r;
      // Result generation
      if (cmd.emit_test) begin
        out_strobe_r <= 1'b1;
        out_r.result_kind <= 1'b0;
        out_r.inside_res <= hit;
        out_r.pen_species <= '0;
        out_r.species_valid <= 1'b0;
        out_r.vertex_overflow <= ovf_r;
        out_r.contained_count <= (hit && tally_r != 8'hFF) ? tally_r + 1'b1 : tally_r;
        if (hit) begin
          if (tally_r == '0) first_r <= tag_r;
          else if (tag_r != first_r) agree_r <= 1'b0;
          if (tally_r != 8'hFF) tally_r <= tally_r + 1'b1;
        end
      end
      if (cmd.emit_close) begin
        out_strobe_r <= 1'b1;
        out_r.result_kind <= 1'b1;
        out_r.inside_res <= 1'b0;
        out_r.species_valid <= (tally_r != '0) && agree_r;
        out_r.pen_species <= ((tally_r != '0) && agree_r) ? first_r : '0;
        out_r.contained_count <= tally_r;
        out_r.vertex_overflow <= ovf_r;
      end
    end
  end

  assign stat.vtotal = vtotal_r;
  assign stat.in_box = (vtotal_r != '0) &&
                       !(px_r < bminx_r || px_r > bmaxx_r ||
                         pz_r < bminz_r || pz_r > bmaxz_r);
  assign out_strobe = out_strobe_r;
  assign out_item = out_r;
endmodule

/* design/pcc_ctrl.sv */
// Controller: sequences clear, add, edge walk and result emission.
module pcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  pcc_pkg::stat_t    stat,
  output logic              busy,
  output pcc_pkg::cmd_t     cmd
);
  import pcc_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic [1:0] req_r, req_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      drain_r <= '0;
      req_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      drain_r <= drain_nxt;
      req_r <= req_nxt;
    end
  end

  // Walk: read vertex 0, then 1..n-1, then vertex 0 again as the closing end
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    drain_nxt = drain_r;
    req_nxt = req_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          req_nxt = req_type;
          unique case (req_t'(req_type))
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_ADD:   cmd.add = 1'b1;
            REQ_TEST: begin
              cnt_nxt = '0;
              state_nxt = (stat.vtotal == '0) ? ST_DONE : ST_READ;
            end
            REQ_CLOSE: state_nxt = ST_DONE;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        cmd.first_rd = (cnt_r == '0);
        cmd.edge_idx = (cnt_r >= stat.vtotal) ? '0 : cnt_r[IDX_BITS-1:0];
        if (cnt_r >= stat.vtotal) begin
          drain_nxt = 2'd3;
          state_nxt = ST_MUL;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_MUL: begin
        drain_nxt = drain_r - 1'b1;
        if (drain_r == 2'd1) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (req_t'(req_r) == REQ_TEST) cmd.emit_test = 1'b1;
        else cmd.emit_close = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

/* design/polygon_containment_classifier.sv */
// Top level: polygon containment classifier.
// Usage:
//   Pulse start with a request on in_item while busy is low; the request
//   is taken at that edge. Clear (0) and add-vertex (1) finish in the same
//   cycle and give no result. A test (2) walks all stored edges, one vertex
//   read per cycle from the vertex memory, and returns one result once the
//   last edge has passed the read and multiply registers (straight after
//   start when no vertex is stored). Close (3) returns the pen verdict without a walk.
//   Results appear on out_item for exactly one cycle with out_valid high;
//   the receiver cannot stall them. busy stays high until the result has
//   been driven. A new request is not taken until the last one is done;
//   the edge walk is bound by the single read port of the vertex memory.
//   Synchronous active-low reset empties the polygon, the box and tallies.
//   Vertex memory contents are not cleared; only stored entries are read.
//   Vertices past capacity are dropped and flagged in vertex_overflow.
module polygon_containment_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pcc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_item.req_type),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  pcc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_strobe(out_valid), .out_item(out_item)
  );
endmodule

/* tb/sv/polygon_containment_classifier_test.sv */
// Testbench for the polygon containment classifier: random polygons, point tests and verdicts.
module polygon_containment_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcc_pkg::*;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN_CYCLES = 100;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;

  // Shadow copy of the pen state plus the queue of predicted results
  class pen_scoreboard;
    out_item_t pending[$];
    longint    vx[MAX_VERTICES];
    longint    vz[MAX_VERTICES];
    int        nvert;
    longint    bx0, bx1, bz0, bz1;
    int        tally;
    logic [SPECIES_BITS-1:0] tag0;
    bit        agree, ovf;
    int        errors, tests, closes, hits, overflows, saturated;

    function new();
      errors = 0; tests = 0; closes = 0; hits = 0; overflows = 0; saturated = 0;
      wipe();
    endfunction

    function void wipe();
      nvert = 0; bx0 = 0; bx1 = 0; bz0 = 0; bz1 = 0;
      tally = 0; tag0 = '0; agree = 1; ovf = 0;
    endfunction

    function longint mag(longint d);
      return (d < 0) ? -d : d;
    endfunction

    // Does the +x ray from the point cross the edge s-e (exact, no division)
    function bit crosses(longint px, longint pz, longint sx, longint sz,
                         longint ex, longint ez);
      longint dx, dz, qx, qz, lm, rm;
      bit ln, rn;
      if ((pz > sz) == (pz > ez)) return 0;
      dx = ex - sx;
      dz = ez - sz;
      qx = px - sx;
      qz = pz - sz;
      ln = qx < 0;
      lm = mag(qx) * mag(dz);
      rn = ((qz < 0) != (dx < 0)) != (dz < 0);
      rm = mag(qz) * mag(dx);
      if (lm == 0) ln = 0;
      if (rm == 0) rn = 0;
      if (ln != rn) return ln;
      if (!ln) return lm < rm;
      return lm > rm;
    endfunction

    function bit contains(longint px, longint pz);
      bit odd;
      int j;
      odd = 0;
      if (nvert == 0) return 0;
      if (px < bx0 || px > bx1 || pz < bz0 || pz > bz1) return 0;
      for (int i = 0; i < nvert; i++) begin
        j = (i + 1 < nvert) ? i + 1 : 0;
        if (crosses(px, pz, vx[i], vz[i], vx[j], vz[j])) odd = !odd;
      end
      return odd;
    endfunction

    // Accepted request transaction: update shadow state, queue any result
    function void note_request(in_item_t it);
      longint px, pz;
      bit in;
      out_item_t r;
      px = longint'(it.coord_x);
      pz = longint'(it.coord_z);
      r = '0;
      case (req_t'(it.req_type))
        REQ_CLEAR: wipe();
        REQ_ADD: begin
          if (nvert >= MAX_VERTICES) begin
            if (!ovf) overflows++;
            ovf = 1;
          end else begin
            if (nvert == 0) begin
              bx0 = px; bx1 = px; bz0 = pz; bz1 = pz;
            end else begin
              if (px < bx0) bx0 = px;
              if (px > bx1) bx1 = px;
              if (pz < bz0) bz0 = pz;
              if (pz > bz1) bz1 = pz;
            end
            vx[nvert] = px;
            vz[nvert] = pz;
            nvert++;
          end
        end
        REQ_TEST: begin
          in = contains(px, pz);
          tests++;
          if (in) begin
            hits++;
            if (tally == 0) tag0 = it.animal_species;
            else if (it.animal_species != tag0) agree = 0;
            if (tally < 255) tally++;
            else saturated++;
          end
          r.result_kind = 1'b0;
          r.inside_res = in;
          r.contained_count = tally[7:0];
          r.vertex_overflow = ovf;
          pending = {pending, r};
        end
        default: begin
          closes++;
          r.result_kind = 1'b1;
          r.species_valid = (tally != 0) && agree;
          r.pen_species = r.species_valid ? tag0 : '0;
          r.contained_count = tally[7:0];
          r.vertex_overflow = ovf;
          pending = {pending, r};
        end
      endcase
    endfunction

    function void field_check(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    // Result transaction: compare against the oldest prediction
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_check("result_kind", e.result_kind, got.result_kind);
      field_check("inside_res", e.inside_res, got.inside_res);
      field_check("pen_species", e.pen_species, got.pen_species);
      field_check("species_valid", e.species_valid, got.species_valid);
      field_check("contained_count", e.contained_count, got.contained_count);
      field_check("vertex_overflow", e.vertex_overflow, got.vertex_overflow);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  pen_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;
  int cycles = 0;

  polygon_containment_classifier u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // Monitor: pre-edge values decide what the block takes and gives
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
    if (rst_n && start && !busy) sb.note_request(in_item);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** polygon_containment_classifier: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t mk(req_t rq, longint x, longint z, int sp);
    in_item_t it;
    it.req_type = rq;
    it.coord_x = x[COORD_BITS-1:0];
    it.coord_z = z[COORD_BITS-1:0];
    it.animal_species = sp[SPECIES_BITS-1:0];
    return it;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Hold start until the block takes the request, then maybe idle
  task automatic send(in_item_t it);
    int gap;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_test(longint x, longint z, int sp);
    send(mk(REQ_TEST, x, z, sp));
  endtask

  // One random polygon followed by a batch of tests and verdicts
  task automatic polygon_round();
    longint lo_x, hi_x, lo_z, hi_z, cx, cz, r, x, z;
    longint px[$], pz[$];
    int n, sp, k, sel;
    px = {}; pz = {};
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      lo_x = COORD_MIN; hi_x = COORD_MAX; lo_z = COORD_MIN; hi_z = COORD_MAX;
    end else begin
      r = longint'($urandom_range(4, 200000));
      cx = pick(COORD_MIN + r, COORD_MAX - r);
      cz = pick(COORD_MIN + r, COORD_MAX - r);
      lo_x = cx - r; hi_x = cx + r; lo_z = cz - r; hi_z = cz + r;
    end
    if ($urandom_range(0, 7) == 0) n = $urandom_range(58, 70);
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 2);
    else n = $urandom_range(3, 12);
    if ($urandom_range(0, 3) != 0) send(mk(REQ_CLEAR, pick(lo_x, hi_x), 0, $urandom));
    for (int i = 0; i < n; i++) begin
      if (n == 4 && $urandom_range(0, 1) == 1) begin
        x = (i == 0 || i == 3) ? lo_x : hi_x;
        z = (i < 2) ? lo_z : hi_z;
      end else begin
        x = pick(lo_x, hi_x);
        z = pick(lo_z, hi_z);
      end
      px = {px, x}; pz = {pz, z};
      send(mk(REQ_ADD, x, z, $urandom));
    end
    sp = $urandom_range(0, 15);
    k = $urandom_range(4, 14);
    for (int i = 0; i < k; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60 || px.size() == 0) begin
        x = pick(lo_x, hi_x); z = pick(lo_z, hi_z);
      end else if (sel < 80) begin
        n = $urandom_range(0, px.size() - 1);
        x = px[n]; z = pz[n];
      end else begin
        x = pick(COORD_MIN, COORD_MAX); z = pick(COORD_MIN, COORD_MAX);
      end
      if ($urandom_range(0, 99) < 10) send(mk(REQ_CLOSE, x, z, $urandom));
      send_test(x, z, ($urandom_range(0, 99) < 85) ? sp : $urandom_range(0, 15));
    end
    send(mk(REQ_CLOSE, 0, 0, $urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pen, full-range square, small triangle, mixed species
    send(mk(REQ_CLEAR, 0, 0, 0));
    send_test(0, 0, 1);
    send(mk(REQ_CLOSE, 0, 0, 0));
    send(mk(REQ_ADD, COORD_MIN, COORD_MIN, 0));
    send(mk(REQ_ADD, COORD_MAX, COORD_MIN, 0));
    send_test(0, 0, 2);
    send(mk(REQ_ADD, COORD_MAX, COORD_MAX, 0));
    send(mk(REQ_ADD, COORD_MIN, COORD_MAX, 0));
    send_test(0, 0, 15);
    send_test(COORD_MIN, COORD_MIN, 15);
    send_test(COORD_MAX, 0, 15);
    send_test(0, COORD_MAX, 15);
    send(mk(REQ_CLOSE, 0, 0, 0));
    send(mk(REQ_CLEAR, 0, 0, 0));
    send(mk(REQ_ADD, 0, 0, 0));
    send(mk(REQ_ADD, 1024, 0, 0));
    send(mk(REQ_ADD, 0, 1024, 0));
    send_test(100, 100, 3);
    send_test(2000, 2000, 3);
    send_test(600, 600, 3);
    send(mk(REQ_CLOSE, 0, 0, 0));
    send_test(10, 10, 5);
    send(mk(REQ_CLOSE, 0, 0, 0));

    // Random polygons across the three idling phases
    while (sent < 600) begin
      idle_pct = (sent < 220) ? 24 : (sent < 420) ? 55 : 0;
      polygon_round();
    end
    idle_pct = 0;

    // Tally saturation on one pen, then a mixed species after the cap
    send(mk(REQ_CLEAR, 0, 0, 0));
    send(mk(REQ_ADD, -4096, -4096, 0));
    send(mk(REQ_ADD, 4096, -4096, 0));
    send(mk(REQ_ADD, 4096, 4096, 0));
    send(mk(REQ_ADD, -4096, 4096, 0));
    for (int i = 0; i < 258; i++) send_test(pick(-4000, 4000), pick(-4000, 4000), 9);
    send(mk(REQ_CLOSE, 0, 0, 0));
    send_test(0, 0, 4);
    send(mk(REQ_CLOSE, 0, 0, 0));
    start <= 1'b0;

    // Drain outstanding results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;

    $display("Covered %0d requests: %0d point tests (%0d inside), %0d verdicts.",
             sent, sb.tests, sb.hits, sb.closes);
    $display("Pens with dropped vertices: %0d; inside points past the cap: %0d.",
             sb.overflows, sb.saturated);
    if (sb.errors == 0) begin
      $display("** polygon_containment_classifier: PASSED **");
    end else begin
      $display("** polygon_containment_classifier: FAILED **");
    end
    $finish;
  end
endmodule
